### sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and codes for the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_LIST       = 3'd4,
    FN_CLEAR      = 3'd5
  } func_e_t;

  typedef enum logic [2:0] {
    STAT_PUSHED  = 3'd0,
    STAT_POPPED  = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_LISTED  = 3'd3,
    STAT_CLEARED = 3'd4,
    STAT_FULL    = 3'd5
  } status_e_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_e_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e_t;

  typedef struct packed {
    cell_op_e_t         op;
    logic [DataW-1:0]   value;
  } cell_ctl_t;

endpackage

### sv/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// one storage cell of the queue chain; position 0 is the front
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                     clk,
  input  dq_pkg::cell_ctl_t        ctl,
  input  logic                     is_end,
  input  logic [dq_pkg::DataW-1:0] prev_data,
  input  logic [dq_pkg::DataW-1:0] next_data,
  input  logic [dq_pkg::DataW-1:0] head_data,
  output logic [dq_pkg::DataW-1:0] data
);
  import dq_pkg::*;

  logic [DataW-1:0] data_r;
  logic [DataW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_HOLD:       data_nxt = data_r;
      CELL_PUSH_FRONT: data_nxt = prev_data;
      CELL_PUSH_BACK:  data_nxt = is_end ? ctl.value : data_r;
      CELL_POP_FRONT:  data_nxt = next_data;
      CELL_ROTATE:     data_nxt = is_end ? head_data : next_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### sv/double_ended_queue_unit.sv
// push, pop and clear: result registered in the cycle after the input beat
// one input beat per cycle while results are taken
// list of n entries: n result beats, one per cycle while results are taken, paced by the chain rotation
// input is stalled while a list streams out
// synchronous active-low reset empties the queue; cell contents are left as is
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded deque of 32-bit values held in a shifting chain of cells
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last
);
  import dq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e_t         state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_e_t        out_status_r, out_status_nxt;
  logic [DataW-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctl_t        ctl;
  logic [CW-1:0]    end_pos;
  logic [DataW-1:0] cell_q [DEPTH];
  logic [DEPTH-1:0] tail_hit;
  logic [DataW-1:0] tail_data;
  logic             in_acc;
  logic             slot_free;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DataW-1:0] prev_d;
      logic [DataW-1:0] next_d;
      if (gi == 0) begin : g_first
        assign prev_d = in_value;
      end else begin : g_mid
        assign prev_d = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_lastc
        assign next_d = cell_q[gi];
      end else begin : g_midn
        assign next_d = cell_q[gi+1];
      end
      assign tail_hit[gi] = (CW'(gi + 1) == count_r);
      dq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .is_end    (CW'(gi) == end_pos),
        .prev_data (prev_d),
        .next_data (next_d),
        .head_data (cell_q[0]),
        .data      (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    tail_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (tail_hit[k]) begin
        tail_data = tail_data | cell_q[k];
      end
    end
  end

  assign in_stall  = (state_r == S_LIST) | (out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    ctl.op         = CELL_HOLD;
    ctl.value      = in_value;
    end_pos        = count_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (func_e_t'(in_func))
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                out_status_nxt = STAT_PUSHED;
                count_nxt      = count_r + 1'b1;
                ctl.op = (func_e_t'(in_func) == FN_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                               : CELL_PUSH_BACK;
              end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
                out_data_nxt   = '0;
              end else begin
                out_status_nxt = STAT_POPPED;
                count_nxt      = count_r - 1'b1;
                if (func_e_t'(in_func) == FN_POP_FRONT) begin
                  out_data_nxt = cell_q[0];
                  ctl.op       = CELL_POP_FRONT;
                end else begin
                  out_data_nxt = tail_data;
                end
              end
            end
            FN_LIST: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
                out_data_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = S_LIST;
                left_nxt  = count_r;
              end
            end
            FN_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_CLEARED;
              out_data_nxt   = '0;
              out_last_nxt   = 1'b1;
            end
            default: begin
              out_valid_nxt = out_valid_r & out_stall;
            end
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_LISTED;
          out_data_nxt   = cell_q[0];
          out_last_nxt   = (left_r == CW'(1));
          ctl.op         = CELL_ROTATE;
          end_pos        = count_r - 1'b1;
          left_nxt       = left_r - 1'b1;
          if (left_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

### sv/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// port-level checks for the double-ended queue
// ----------------------------------------------------------------------------
module dq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         in_func,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic signed [31:0] out_data,
  input logic               out_last
);
  import dq_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_status)
      && $stable(out_last))
    else $error("stalled result beat changed");

  // only listed entries may be non-final
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_LISTED |-> out_last)
    else $error("single-result beat without last");

  // statuses without a value carry zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_PUSHED || out_status == STAT_EMPTY ||
      out_status == STAT_CLEARED || out_status == STAT_FULL) |-> out_data == '0)
    else $error("nonzero data on status-only beat");

  // clear answers in the next cycle
  a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FN_CLEAR |=> out_valid && out_status == STAT_CLEARED)
    else $error("clear not answered");

  // input stays stalled while a list streams
  a_list_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_LISTED && !out_last |-> in_stall)
    else $error("input taken during list");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);
